/* hdl/rpn_pkg.sv */
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int SYMBOL_W    = 8;
   localparam int STATUS_W    = 3;

   localparam logic [SYMBOL_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] ASCII_NINE  = 8'h39;
   localparam logic [SYMBOL_W-1:0] ASCII_PLUS  = 8'h2B;
   localparam logic [SYMBOL_W-1:0] ASCII_MINUS = 8'h2D;
   localparam logic [SYMBOL_W-1:0] ASCII_STAR  = 8'h2A;
   localparam logic [SYMBOL_W-1:0] ASCII_SLASH = 8'h2F;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDER = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DIVZ  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_SYM   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_COUNT = 3'd5;

endpackage

/* hdl/rpn_if.sv */
interface rpn_req_if;
   logic                          valid;
   logic                          ready;
   logic [rpn_pkg::SYMBOL_W-1:0]  symbol;
   logic                          end_of_expression;

   modport source (output valid, symbol, end_of_expression, input ready);
   modport sink   (input valid, symbol, end_of_expression, output ready);
endinterface

interface rpn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [rpn_pkg::WORD_W-1:0]   value;
   logic [rpn_pkg::STATUS_W-1:0]        status;

   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

/* hdl/rpn_divider.sv */
module rpn_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rpn_pkg::WORD_W-1:0]   dividend,
   input  logic [rpn_pkg::WORD_W-1:0]   divisor,
   output logic                         done,
   output logic [rpn_pkg::WORD_W-1:0]   quotient
);
   import rpn_pkg::*;

   localparam int STEP_W = $clog2(WORD_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [WORD_W-1:0]   rem_ff, rem_in;
   logic [WORD_W-1:0]   quo_ff, quo_in;
   logic [WORD_W-1:0]   den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [WORD_W-1:0]   result_ff, result_in;

   logic [WORD_W:0]     rem_shift;
   logic [WORD_W:0]     trial;
   logic                fits;

   // magnitudes are taken here; the sign is put back after the last step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[WORD_W-1]};
      trial     = rem_shift - {1'b0, den_ff};
      fits      = !trial[WORD_W];

      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      result_in = result_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
         den_in  = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
         neg_in  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? trial[WORD_W-1:0] : rem_shift[WORD_W-1:0];
         quo_in  = {quo_ff[WORD_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(WORD_W - 1)) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = neg_ff ? (WORD_W'(0) - quo_in) : quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign done     = done_ff;
   assign quotient = result_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");

endmodule

/* hdl/postfix_expression_evaluator.sv */
// Each symbol is accepted in the idle state, then the execute state does the
// stack read-modify-write. An end-of-expression symbol adds an emit state to
// load the response register; a '/' adds a divide state, in which the divider
// resolves one quotient bit per cycle. Symbols are taken one at a time: ready
// is high only in idle. Reset is synchronous: it clears the state, the stack
// count, error and response valid; stack RAM keeps contents, needs no clearing.
module postfix_expression_evaluator (
   input  logic     clock,
   input  logic     reset,
   rpn_req_if.sink  req_chan,
   rpn_rsp_if.source rsp_chan
);
   import rpn_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [STATUS_W-1:0]    err_ff, err_in;
   logic [WORD_W-1:0]      top_ff, top_in;
   logic [SYMBOL_W-1:0]    sym_ff;
   logic                   eoe_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]      rsp_value_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;

   logic [WORD_W-1:0]      stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0]      rd_top_ff, rd_sec_ff;
   logic [CNT_W-1:0]       cnt_m1, cnt_m2;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [WORD_W-1:0]      wr_data;

   logic                   accept;
   logic                   emit;
   logic                   is_digit;
   logic [SYMBOL_W-1:0]    digit_val;
   logic [WORD_W-1:0]      alu_res;
   logic [WORD_W-1:0]      prod;
   logic                   div_start;
   logic                   div_done;
   logic [WORD_W-1:0]      div_quo;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign emit           = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   assign cnt_m1    = cnt_ff - CNT_W'(1);
   assign cnt_m2    = cnt_ff - CNT_W'(2);
   assign is_digit  = (sym_ff >= ASCII_ZERO) && (sym_ff <= ASCII_NINE);
   assign digit_val = sym_ff - ASCII_ZERO;
   assign prod      = rd_sec_ff * rd_top_ff;

   always_comb begin
      case (sym_ff)
         ASCII_PLUS:  alu_res = rd_sec_ff + rd_top_ff;
         ASCII_MINUS: alu_res = rd_sec_ff - rd_top_ff;
         default:     alu_res = prod;
      endcase
   end

   rpn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_sec_ff),
      .divisor  (rd_top_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      top_in    = top_ff;
      wr_en     = 1'b0;
      wr_addr   = cnt_m2[ADDR_W-1:0];
      wr_data   = alu_res;
      div_start = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            top_in = (cnt_ff != '0) ? rd_top_ff : '0;
            if (err_ff == STATUS_OK) begin
               if (is_digit) begin
                  if (cnt_ff >= CNT_W'(STACK_DEPTH)) begin
                     err_in = STATUS_OVER;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = cnt_ff[ADDR_W-1:0];
                     wr_data = {{(WORD_W-SYMBOL_W){1'b0}}, digit_val};
                     cnt_in  = cnt_ff + CNT_W'(1);
                     top_in  = wr_data;
                  end
               end else if (sym_ff != ASCII_PLUS && sym_ff != ASCII_MINUS &&
                            sym_ff != ASCII_STAR && sym_ff != ASCII_SLASH) begin
                  err_in = STATUS_SYM;
               end else if (cnt_ff < CNT_W'(2)) begin
                  err_in = STATUS_UNDER;
               end else if (sym_ff == ASCII_SLASH) begin
                  if (rd_top_ff == '0) err_in = STATUS_DIVZ;
                  else div_start = 1'b1;
               end else begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_m1;
                  top_in = alu_res;
               end
            end
            if (div_start)    state_in = ST_DIV;
            else if (eoe_ff)  state_in = ST_EMIT;
            else              state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) begin
               wr_en    = 1'b1;
               wr_data  = div_quo;
               cnt_in   = cnt_m1;
               top_in   = div_quo;
               state_in = eoe_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               cnt_in   = '0;
               err_in   = STATUS_OK;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;
      if (emit) rsp_valid_in = 1'b1;
   end

   // stack RAM: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      if (state_ff == ST_IDLE) begin
         rd_top_ff <= stack_mem[cnt_m1[ADDR_W-1:0]];
         rd_sec_ff <= stack_mem[cnt_m2[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff <= top_in;
      if (accept) begin
         sym_ff <= req_chan.symbol;
         eoe_ff <= req_chan.end_of_expression;
      end
      if (emit) begin
         rsp_value_ff <= top_ff;
         if (err_ff != STATUS_OK)         rsp_status_ff <= err_ff;
         else if (cnt_ff != CNT_W'(1))    rsp_status_ff <= STATUS_COUNT;
         else                             rsp_status_ff <= STATUS_OK;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.value  = rsp_value_ff;
   assign rsp_chan.status = rsp_status_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted beat not executed");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != STATUS_OK && !emit) |=> err_ff == $past(err_ff))
      else $error("error code changed within expression");

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      emit |=> cnt_ff == '0 && err_ff == STATUS_OK && rsp_valid_ff)
      else $error("emit did not clear stack");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider done outside divide state");

endmodule

/* tb/postfix_expression_evaluator_tb.sv */
module postfix_expression_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rpn_pkg::*;

   localparam int RANDOM_ITEMS = 820;
   localparam int DIRECTED_ROWS = 26;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic [STATUS_W-1:0]      status;
   } result_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0]      symbol;
      logic                     last;
      logic                     typed;
      logic signed [WORD_W-1:0] value;
      logic [STATUS_W-1:0]      status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rpn_req_if req_chan ();
   rpn_rsp_if rsp_chan ();

   postfix_expression_evaluator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // operand stack mirror
   logic [WORD_W-1:0]   mirror_stack [STACK_DEPTH];
   int unsigned         mirror_depth = 0;
   logic [STATUS_W-1:0] mirror_error = STATUS_OK;

   result_type expected_results [$];
   bit      idle_on = 1'b1;
   int      symbols_sent = 0;
   int      results_seen = 0;
   int      error_results = 0;
   int      mismatch_count = 0;

   // --- expected behavior -------------------------------------------------
   function automatic logic [WORD_W-1:0] trunc_quotient(logic [WORD_W-1:0] num,
                                                        logic [WORD_W-1:0] den);
      logic [WORD_W-1:0] num_mag;
      logic [WORD_W-1:0] den_mag;
      logic [WORD_W-1:0] quo;
      num_mag = num[WORD_W-1] ? -num : num;
      den_mag = den[WORD_W-1] ? -den : den;
      quo = num_mag / den_mag;
      return (num[WORD_W-1] != den[WORD_W-1]) ? -quo : quo;
   endfunction

   function automatic void evaluate_symbol(input logic [SYMBOL_W-1:0] sym, input logic last,
                                           output bit emits, output result_type res);
      logic [WORD_W-1:0] lhs;
      logic [WORD_W-1:0] rhs;
      logic [WORD_W-1:0] acc;
      emits = 1'b0;
      res = '0;
      if (mirror_error == STATUS_OK) begin
         if (sym >= ASCII_ZERO && sym <= ASCII_NINE) begin
            if (mirror_depth >= STACK_DEPTH) begin
               mirror_error = STATUS_OVER;
            end else begin
               mirror_stack[mirror_depth] = {{(WORD_W-SYMBOL_W){1'b0}}, sym - ASCII_ZERO};
               mirror_depth++;
            end
         end else if (!(sym == ASCII_PLUS || sym == ASCII_MINUS ||
                        sym == ASCII_STAR || sym == ASCII_SLASH)) begin
            mirror_error = STATUS_SYM;
         end else if (mirror_depth < 2) begin
            mirror_error = STATUS_UNDER;
         end else begin
            rhs = mirror_stack[mirror_depth-1];
            lhs = mirror_stack[mirror_depth-2];
            if (sym == ASCII_SLASH && rhs == '0) begin
               mirror_error = STATUS_DIVZ;
            end else begin
               case (sym)
                  ASCII_PLUS:  acc = lhs + rhs;
                  ASCII_MINUS: acc = lhs - rhs;
                  ASCII_STAR:  acc = lhs * rhs;
                  default:     acc = trunc_quotient(lhs, rhs);
               endcase
               mirror_depth--;
               mirror_stack[mirror_depth-1] = acc;
            end
         end
      end
      if (last) begin
         emits = 1'b1;
         res.value = (mirror_depth >= 1) ? mirror_stack[mirror_depth-1] : '0;
         if (mirror_error != STATUS_OK) res.status = mirror_error;
         else if (mirror_depth != 1) res.status = STATUS_COUNT;
         else res.status = STATUS_OK;
         mirror_depth = 0;
         mirror_error = STATUS_OK;
      end
   endfunction

   // --- symbol driver: called at a falling edge, returns at a falling edge --
   task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input logic last,
                              input bit typed = 1'b0,
                              input logic signed [WORD_W-1:0] typed_value = '0,
                              input logic [STATUS_W-1:0] typed_status = STATUS_OK);
      int      gap;
      bit      emits;
      result_type res;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.symbol            <= sym;
      req_chan.end_of_expression <= last;
      req_chan.valid             <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      symbols_sent++;
      evaluate_symbol(sym, last, emits, res);
      if (emits) begin
         if (typed) begin
            res.value  = typed_value;
            res.status = typed_status;
         end
         expected_results.push_back(res);
      end
      @(negedge clock);
   endtask

   function automatic logic [SYMBOL_W-1:0] any_operator();
      case ($urandom_range(0, 3))
         0:       return ASCII_PLUS;
         1:       return ASCII_MINUS;
         2:       return ASCII_STAR;
         default: return ASCII_SLASH;
      endcase
   endfunction

   function automatic logic [SYMBOL_W-1:0] any_digit();
      return ASCII_ZERO + SYMBOL_W'($urandom_range(0, 9));
   endfunction

   // well-formed expression, sometimes cut short
   task automatic send_expression();
      int operands;
      int pushed;
      int depth;
      bit cut_short;
      bit done;
      logic [SYMBOL_W-1:0] sym;
      operands = $urandom_range(1, 12);
      cut_short = ($urandom_range(0, 9) == 0);
      pushed = 0;
      depth = 0;
      done = 1'b0;
      while (!done) begin
         if (depth < 2 || (pushed < operands && $urandom_range(0, 1) == 1)) begin
            sym = any_digit();
            pushed++;
            depth++;
         end else begin
            sym = any_operator();
            depth--;
         end
         done = !(pushed < operands || depth > 1);
         if (cut_short && $urandom_range(0, 3) == 0) done = 1'b1;
         send_symbol(sym, done);
      end
   endtask

   // repeated products reach wide, wrapped values
   task automatic send_wide_chain(input bit most_negative);
      int rounds;
      logic [SYMBOL_W-1:0] base;
      base   = most_negative ? ASCII_ZERO + 8'd2 : ASCII_ZERO + SYMBOL_W'($urandom_range(2, 9));
      rounds = most_negative ? 30 : $urandom_range(4, 20);
      send_symbol(base, 1'b0);
      repeat (rounds) begin
         send_symbol(base, 1'b0);
         send_symbol(ASCII_STAR, 1'b0);
      end
      if (most_negative) begin
         // 2^31 wraps negative, then divide by -1
         send_symbol("0", 1'b0);
         send_symbol("1", 1'b0);
         send_symbol(ASCII_MINUS, 1'b0);
         send_symbol(ASCII_SLASH, 1'b1);
      end else begin
         send_symbol(any_digit(), 1'b0);
         send_symbol(any_operator(), 1'b1);
      end
   endtask

   task automatic send_full_stack();
      int count;
      count = $urandom_range(STACK_DEPTH, STACK_DEPTH + 4);
      for (int i = 1; i <= count; i++) begin
         send_symbol(any_digit(), i == count);
      end
   endtask

   task automatic send_noise();
      int count;
      count = $urandom_range(1, 6);
      for (int i = 1; i <= count; i++) begin
         send_symbol(SYMBOL_W'($urandom_range(0, 255)),
                     (i == count) || ($urandom_range(0, 3) == 0));
      end
   endtask

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{"7",         1'b1, 1'b1, 32'sd7,  STATUS_OK},
      '{ASCII_PLUS,  1'b1, 1'b1, 32'sd0,  STATUS_UNDER},
      '{8'h00,       1'b1, 1'b1, 32'sd0,  STATUS_SYM},
      '{8'hFF,       1'b1, 1'b1, 32'sd0,  STATUS_SYM},
      '{"9",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{"0",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{ASCII_SLASH, 1'b1, 1'b1, 32'sd0,  STATUS_DIVZ},
      '{"8",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{"3",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{ASCII_MINUS, 1'b1, 1'b0, 32'sd0,  STATUS_OK},
      '{"7",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{"2",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{ASCII_SLASH, 1'b1, 1'b0, 32'sd0,  STATUS_OK},
      '{"6",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{"9",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{ASCII_STAR,  1'b1, 1'b0, 32'sd0,  STATUS_OK},
      '{"4",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{"5",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{ASCII_PLUS,  1'b1, 1'b0, 32'sd0,  STATUS_OK},
      '{"3",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{"4",         1'b1, 1'b1, 32'sd4,  STATUS_COUNT},
      '{ASCII_MINUS, 1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{"5",         1'b1, 1'b1, 32'sd0,  STATUS_UNDER},
      '{"2",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{"9",         1'b0, 1'b0, 32'sd0,  STATUS_OK},
      '{ASCII_MINUS, 1'b1, 1'b0, 32'sd0,  STATUS_OK}
   };

   // --- main sequence ---------------------------------------------------------
   initial begin
      int pick;
      req_chan.valid             = 1'b0;
      req_chan.symbol            = '0;
      req_chan.end_of_expression = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_symbol(directed_rows[i].symbol, directed_rows[i].last, directed_rows[i].typed,
                     directed_rows[i].value, directed_rows[i].status);
      end

      while (symbols_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 68) send_expression();
         else if (pick < 76) send_full_stack();
         else if (pick < 86) send_wide_chain($urandom_range(0, 3) == 0);
         else send_noise();
      end
      req_chan.valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("%0d symbols driven, %0d results checked (%0d with an error status)",
               symbols_sent, results_seen, error_results);
      $display("%0d result mismatches", mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // --- result side back-pressure ---------------------------------------------
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = idle_on ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // --- result checking ---------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (rsp_chan.status != STATUS_OK) error_results++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%t unexpected result beat: value %0d status %0d",
                        $realtime, rsp_chan.value, rsp_chan.status);
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.value !== want.value || rsp_chan.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"%t result mismatch: expected value %0d (%h) status %0d, ",
                            "got value %0d (%h) status %0d"},
                           $realtime, want.value, want.value, want.status,
                           rsp_chan.value, rsp_chan.value, rsp_chan.status);
            end
         end
      end
   end

   initial begin
      #8ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
